// ===== hw/rtl/grid_ray_caster_column_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the grid ray caster column
// Concurrent assertion wrappers that are clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GRID_RAY_CASTER_COLUMN_ASSERT_SVH
`define GRID_RAY_CASTER_COLUMN_ASSERT_SVH

// same-cycle implication
`define GRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grc assertion failed");

// next-cycle implication
`define GRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grc assertion failed");

`endif

// ===== hw/rtl/grc_pkg.sv =====
// ---------------------------------------------------------------------------
// grc_pkg
// Types, constants and register indexes of the grid ray caster column.
// ---------------------------------------------------------------------------
package grc_pkg;

  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;
  localparam int GRID_SIZE_DEF     = 64;

  localparam int MAP_DEPTH   = 4096;
  localparam int MAP_AW      = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam int DIV_NW = 31;
  localparam int DIV_DW = 17;

  localparam logic [2:0] REG_CAM_POS_X   = 3'd0;
  localparam logic [2:0] REG_CAM_POS_Y   = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X  = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y  = 3'd3;
  localparam logic [2:0] REG_CAM_PLANE_X = 3'd4;
  localparam logic [2:0] REG_CAM_PLANE_Y = 3'd5;

  localparam logic [15:0] RST_CAM_POS_X   = 16'd0;
  localparam logic [15:0] RST_CAM_POS_Y   = 16'd0;
  localparam logic [15:0] RST_VIEW_DIR_X  = 16'd16384;
  localparam logic [15:0] RST_VIEW_DIR_Y  = 16'd0;
  localparam logic [15:0] RST_CAM_PLANE_X = 16'd0;
  localparam logic [15:0] RST_CAM_PLANE_Y = 16'd10813;

  localparam logic MODE_MAP_WRITE = 1'b0;
  localparam logic MODE_CAST      = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [9:0] column;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [7:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic        wall_side;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic [7:0]  hit_value;
    logic [15:0] wall_distance;
    logic [15:0] line_height;
    logic [9:0]  row_start;
    logic [9:0]  row_end;
    logic        left_grid;
  } out_item_t;

  typedef struct packed {
    logic [15:0] cam_pos_x;
    logic [15:0] cam_pos_y;
    logic [15:0] view_dir_x;
    logic [15:0] view_dir_y;
    logic [15:0] cam_plane_x;
    logic [15:0] cam_plane_y;
  } cam_cfg_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } back_status_t;

endpackage

// ===== hw/rtl/grid_ray_caster_column.sv =====
// A map write is written to the map memory as it leaves the queue; a cast holds the core for
//   up to 5 divisions in the shared divider and a DDA walk of
//   at most 2*GRID_SIZE+4 steps.
// The core works on one item at a time.
// Reset: synchronous; the map memory is then swept to zero, with in_full high;
//   configuration writes are taken during that time.
// ---------------------------------------------------------------------------
// grid_ray_caster_column
// Column ray caster over a square grid map with camera registers.
// ---------------------------------------------------------------------------
`include "grid_ray_caster_column_assert.svh"

module grid_ray_caster_column #(
  parameter int SCREEN_WIDTH  = grc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT_DEF,
  parameter int GRID_SIZE     = grc_pkg::GRID_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  grc_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output grc_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import grc_pkg::*;

  cam_cfg_t     cfg_r, cfg_nxt;
  back_status_t back_status;
  logic         q_valid;
  in_item_t     q_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_CAM_POS_X:   cfg_nxt.cam_pos_x   = cfg_data;
        REG_CAM_POS_Y:   cfg_nxt.cam_pos_y   = cfg_data;
        REG_VIEW_DIR_X:  cfg_nxt.view_dir_x  = cfg_data;
        REG_VIEW_DIR_Y:  cfg_nxt.view_dir_y  = cfg_data;
        REG_CAM_PLANE_X: cfg_nxt.cam_plane_x = cfg_data;
        REG_CAM_PLANE_Y: cfg_nxt.cam_plane_y = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_pos_x   <= RST_CAM_POS_X;
      cfg_r.cam_pos_y   <= RST_CAM_POS_Y;
      cfg_r.view_dir_x  <= RST_VIEW_DIR_X;
      cfg_r.view_dir_y  <= RST_VIEW_DIR_Y;
      cfg_r.cam_plane_x <= RST_CAM_PLANE_X;
      cfg_r.cam_plane_y <= RST_CAM_PLANE_Y;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  grc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .back_status (back_status),
    .q_valid     (q_valid),
    .q_item      (q_item)
  );

  grc_core #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .GRID_SIZE     (GRID_SIZE)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .back_status (back_status),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

  `GRC_ASSERT_IMP(a_clear_blocks_input, back_status.clearing, in_full)
  `GRC_ASSERT_NEXT(a_clear_once, !back_status.clearing, !back_status.clearing)
  `GRC_ASSERT_IMP(a_rows_ordered, !out_empty, out_data.row_start <= out_data.row_end)
  `GRC_ASSERT_IMP(a_hit_nonzero, !out_empty && !out_data.left_grid,
                  out_data.hit_value != 8'd0)

endmodule

// ===== hw/rtl/grc_front.sv =====
// ---------------------------------------------------------------------------
// grc_front
// Input side: accepts items and holds them in a short queue for the core.
// ---------------------------------------------------------------------------
module grc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  grc_pkg::in_item_t     in_data,
  input  grc_pkg::back_status_t back_status,
  output logic                  q_valid,
  output grc_pkg::in_item_t     q_item
);
  import grc_pkg::*;

  in_item_t   q_mem [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push_ok;
  logic       pop_ok;

  assign in_full = (count_r == 2'(QUEUE_DEPTH)) || back_status.clearing;
  assign push_ok = in_push && !in_full;
  assign q_valid = (count_r != 2'd0);
  assign pop_ok  = back_status.take && q_valid;
  assign q_item  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[wr_ptr_r] <= in_data;
    end
  end

endmodule

// ===== hw/rtl/grc_div.sv =====
// ---------------------------------------------------------------------------
// grc_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module grc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [grc_pkg::DIV_NW-1:0]  num,
  input  logic [grc_pkg::DIV_DW-1:0]  den,
  output logic                        done,
  output logic [grc_pkg::DIV_NW-1:0]  quo
);
  import grc_pkg::*;

  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign done  = done_r;
  assign quo   = quo_r;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = 5'(DIV_NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

endmodule

// ===== hw/rtl/grc_core.sv =====
// ---------------------------------------------------------------------------
// grc_core
// Back end: map memory, ray setup, DDA walk, distance and height, result.
// ---------------------------------------------------------------------------
module grc_core #(
  parameter int SCREEN_WIDTH  = grc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT_DEF,
  parameter int GRID_SIZE     = grc_pkg::GRID_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  grc_pkg::cam_cfg_t     cfg,
  input  logic                  q_valid,
  input  grc_pkg::in_item_t     q_item,
  output grc_pkg::back_status_t back_status,
  output logic                  out_empty,
  input  logic                  out_pop,
  output grc_pkg::out_item_t    out_data
);
  import grc_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CAM    = 5'd1;
  localparam logic [4:0] ST_CAM_W  = 5'd2;
  localparam logic [4:0] ST_RAY_X  = 5'd3;
  localparam logic [4:0] ST_RAY_Y  = 5'd4;
  localparam logic [4:0] ST_DX     = 5'd5;
  localparam logic [4:0] ST_DX_W   = 5'd6;
  localparam logic [4:0] ST_DY     = 5'd7;
  localparam logic [4:0] ST_DY_W   = 5'd8;
  localparam logic [4:0] ST_SIDE_X = 5'd9;
  localparam logic [4:0] ST_SIDE_Y = 5'd10;
  localparam logic [4:0] ST_STEP   = 5'd11;
  localparam logic [4:0] ST_CHECK  = 5'd12;
  localparam logic [4:0] ST_DIST   = 5'd13;
  localparam logic [4:0] ST_DIST_W = 5'd14;
  localparam logic [4:0] ST_LH     = 5'd15;
  localparam logic [4:0] ST_LH_W   = 5'd16;
  localparam logic [4:0] ST_LEFT   = 5'd17;
  localparam logic [4:0] ST_OUT    = 5'd18;

  localparam logic [9:0]  COL_MAX    = 10'(SCREEN_WIDTH - 1);
  localparam logic [10:0] COL_LIMIT  = 11'(SCREEN_WIDTH);
  localparam logic [7:0]  GRID_LIM   = 8'(GRID_SIZE);
  localparam logic [7:0]  STEP_LIMIT = 8'(2 * GRID_SIZE + 4);
  localparam logic [9:0]  HALF_H     = 10'(SCREEN_HEIGHT / 2);
  localparam logic [16:0] H_FULL     = 17'(SCREEN_HEIGHT);
  localparam logic [9:0]  H_LAST     = 10'(SCREEN_HEIGHT - 1);
  localparam logic [40:0] DELTA_SAT  = 41'h100_0000_0000;
  localparam logic [15:0] Q14_ONE    = 16'd16384;

  logic [7:0] map_mem [MAP_DEPTH];

  logic [4:0]         state_r, state_nxt;
  logic [9:0]         col_r, col_nxt;
  logic [9:0]         c_r, c_nxt;
  logic signed [15:0] cam_r, cam_nxt;
  logic signed [17:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [40:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic [49:0]        sdx_r, sdx_nxt, sdy_r, sdy_nxt;
  logic signed [7:0]  mx_r, mx_nxt, my_r, my_nxt;
  logic [7:0]         steps_r, steps_nxt;
  logic               side_r, side_nxt;
  logic               left_r, left_nxt;
  logic [7:0]         val_r, val_nxt;
  logic [15:0]        dist_r, dist_nxt;
  logic [15:0]        lh_r, lh_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MAP_AW-1:0]  clr_addr_r;
  logic               clearing_r;
  logic [7:0]         rd_data_r;

  logic                take;
  logic                mem_we;
  logic [MAP_AW-1:0]   mem_wa;
  logic [7:0]          mem_wd;
  logic [MAP_AW-1:0]   mem_ra;

  logic                div_start;
  logic [DIV_NW-1:0]   div_num;
  logic [DIV_DW-1:0]   div_den;
  logic                div_done;
  logic [DIV_NW-1:0]   div_quo;
  logic [15:0]         div_sat;

  logic signed [15:0]  ray_a;
  logic signed [31:0]  ray_prod;
  logic signed [31:0]  ray_shift;
  logic [10:0]         side_a;
  logic [40:0]         side_b;
  logic [51:0]         side_prod;
  logic [9:0]          fx, fy;

  logic [17:0]         mag_rx, mag_ry;
  logic signed [17:0]  dnum;
  logic [17:0]         dnum_mag;
  logic [16:0]         dden;

  logic [14:0]         lh_half;
  logic [16:0]         row_sum;
  logic [9:0]          row_s, row_e;
  logic                oob;

  assign take = (state_r == ST_IDLE) && q_valid && !clearing_r;
  assign back_status.take     = take;
  assign back_status.clearing = clearing_r;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  assign fx = cfg.cam_pos_x[9:0];
  assign fy = cfg.cam_pos_y[9:0];
  assign mag_rx = rx_r[17] ? 18'(-rx_r) : 18'(rx_r);
  assign mag_ry = ry_r[17] ? 18'(-ry_r) : 18'(ry_r);

  // shared multipliers
  assign ray_a     = (state_r == ST_RAY_X) ? $signed(cfg.cam_plane_x)
                                           : $signed(cfg.cam_plane_y);
  assign ray_prod  = ray_a * cam_r;
  assign ray_shift = ray_prod >>> 14;

  always_comb begin
    if (state_r == ST_SIDE_X) begin
      side_a = rx_r[17] ? {1'b0, fx} : (11'd1024 - {1'b0, fx});
      side_b = dx_r;
    end else begin
      side_a = ry_r[17] ? {1'b0, fy} : (11'd1024 - {1'b0, fy});
      side_b = dy_r;
    end
  end
  assign side_prod = {41'd0, side_a} * {11'd0, side_b};

  // offset to the near face of the hit cell
  always_comb begin
    if (side_r == 1'b0) begin
      dnum = $signed({2'b00, mx_r[5:0], 10'd0}) - $signed({2'b00, cfg.cam_pos_x})
             + (rx_r[17] ? 18'sd1024 : 18'sd0);
      dden = mag_rx[16:0];
    end else begin
      dnum = $signed({2'b00, my_r[5:0], 10'd0}) - $signed({2'b00, cfg.cam_pos_y})
             + (ry_r[17] ? 18'sd1024 : 18'sd0);
      dden = mag_ry[16:0];
    end
    dnum_mag = dnum[17] ? 18'(-dnum) : 18'(dnum);
  end

  assign div_sat = (div_quo[DIV_NW-1:16] != '0) ? 16'hFFFF : div_quo[15:0];

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      ST_CAM: begin
        div_start = 1'b1;
        div_num   = DIV_NW'({c_r, 15'd0});
        div_den   = DIV_DW'(SCREEN_WIDTH);
      end
      ST_DX: begin
        div_start = (rx_r != '0);
        div_num   = DIV_NW'(32'h4000_0000);
        div_den   = mag_rx[16:0];
      end
      ST_DY: begin
        div_start = (ry_r != '0);
        div_num   = DIV_NW'(32'h4000_0000);
        div_den   = mag_ry[16:0];
      end
      ST_DIST: begin
        div_start = (dden != '0);
        div_num   = DIV_NW'({dnum_mag[16:0], 12'd0});
        div_den   = dden;
      end
      ST_LH: begin
        div_start = (dist_r != '0);
        div_num   = DIV_NW'(SCREEN_HEIGHT * 256);
        div_den   = {1'b0, dist_r};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  grc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign oob = mx_r[7] || my_r[7] || (mx_r >= $signed(GRID_LIM))
               || (my_r >= $signed(GRID_LIM));

  assign lh_half = lh_r[15:1];
  assign row_sum = {7'd0, HALF_H} + {2'd0, lh_half};
  assign row_s   = ({5'd0, HALF_H} <= lh_half) ? 10'd0 : (HALF_H - lh_half[9:0]);
  assign row_e   = (row_sum >= H_FULL) ? H_LAST : row_sum[9:0];

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    c_nxt         = c_r;
    cam_nxt       = cam_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sdx_nxt       = sdx_r;
    sdy_nxt       = sdy_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    steps_nxt     = steps_r;
    side_nxt      = side_r;
    left_nxt      = left_r;
    val_nxt       = val_r;
    dist_nxt      = dist_r;
    lh_nxt        = lh_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    case (state_r)
      ST_IDLE: begin
        if (take && (q_item.mode == MODE_CAST)) begin
          col_nxt   = q_item.column;
          c_nxt     = ({1'b0, q_item.column} >= COL_LIMIT) ? COL_MAX : q_item.column;
          left_nxt  = 1'b0;
          side_nxt  = 1'b0;
          val_nxt   = '0;
          state_nxt = ST_CAM;
        end
      end
      ST_CAM: state_nxt = ST_CAM_W;
      ST_CAM_W: begin
        if (div_done) begin
          cam_nxt   = $signed(div_quo[15:0] - Q14_ONE);
          state_nxt = ST_RAY_X;
        end
      end
      ST_RAY_X: begin
        rx_nxt    = 18'($signed(cfg.view_dir_x)) + 18'(ray_shift);
        state_nxt = ST_RAY_Y;
      end
      ST_RAY_Y: begin
        ry_nxt    = 18'($signed(cfg.view_dir_y)) + 18'(ray_shift);
        state_nxt = ST_DX;
      end
      ST_DX: begin
        if (rx_r == '0) begin
          dx_nxt    = DELTA_SAT;
          state_nxt = ST_DY;
        end else begin
          state_nxt = ST_DX_W;
        end
      end
      ST_DX_W: begin
        if (div_done) begin
          dx_nxt    = 41'(div_quo);
          state_nxt = ST_DY;
        end
      end
      ST_DY: begin
        if (ry_r == '0) begin
          dy_nxt    = DELTA_SAT;
          state_nxt = ST_SIDE_X;
        end else begin
          state_nxt = ST_DY_W;
        end
      end
      ST_DY_W: begin
        if (div_done) begin
          dy_nxt    = 41'(div_quo);
          state_nxt = ST_SIDE_X;
        end
      end
      ST_SIDE_X: begin
        sdx_nxt   = 50'(side_prod >> 10);
        mx_nxt    = $signed({2'b00, cfg.cam_pos_x[15:10]});
        my_nxt    = $signed({2'b00, cfg.cam_pos_y[15:10]});
        steps_nxt = '0;
        state_nxt = ST_SIDE_Y;
      end
      ST_SIDE_Y: begin
        sdy_nxt   = 50'(side_prod >> 10);
        state_nxt = oob ? ST_LEFT : ST_STEP;
      end
      ST_STEP: begin
        if (sdx_r < sdy_r) begin
          sdx_nxt  = sdx_r + {9'd0, dx_r};
          mx_nxt   = rx_r[17] ? (mx_r - 8'sd1) : (mx_r + 8'sd1);
          side_nxt = 1'b0;
        end else begin
          sdy_nxt  = sdy_r + {9'd0, dy_r};
          my_nxt   = ry_r[17] ? (my_r - 8'sd1) : (my_r + 8'sd1);
          side_nxt = 1'b1;
        end
        steps_nxt = steps_r + 8'd1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (oob) begin
          state_nxt = ST_LEFT;
        end else if (rd_data_r != 8'd0) begin
          val_nxt   = rd_data_r;
          state_nxt = ST_DIST;
        end else if (steps_r == STEP_LIMIT) begin
          state_nxt = ST_LEFT;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_DIST: begin
        if (dden == '0) begin
          dist_nxt  = 16'hFFFF;
          state_nxt = ST_LH;
        end else begin
          state_nxt = ST_DIST_W;
        end
      end
      ST_DIST_W: begin
        if (div_done) begin
          dist_nxt  = div_sat;
          state_nxt = ST_LH;
        end
      end
      ST_LH: begin
        if (dist_r == '0) begin
          lh_nxt    = 16'hFFFF;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_LH_W;
        end
      end
      ST_LH_W: begin
        if (div_done) begin
          lh_nxt    = div_sat;
          state_nxt = ST_OUT;
        end
      end
      ST_LEFT: begin
        left_nxt  = 1'b1;
        dist_nxt  = 16'hFFFF;
        lh_nxt    = '0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_nxt.column_out    = col_r;
          out_nxt.wall_side     = side_r;
          out_nxt.hit_x         = left_r ? 6'd0 : mx_r[5:0];
          out_nxt.hit_y         = left_r ? 6'd0 : my_r[5:0];
          out_nxt.hit_value     = left_r ? 8'd0 : val_r;
          out_nxt.wall_distance = dist_r;
          out_nxt.line_height   = lh_r;
          out_nxt.row_start     = row_s;
          out_nxt.row_end       = row_e;
          out_nxt.left_grid     = left_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == MAP_AW'(MAP_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r   <= col_nxt;
    c_r     <= c_nxt;
    cam_r   <= cam_nxt;
    rx_r    <= rx_nxt;
    ry_r    <= ry_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    sdx_r   <= sdx_nxt;
    sdy_r   <= sdy_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    steps_r <= steps_nxt;
    side_r  <= side_nxt;
    left_r  <= left_nxt;
    val_r   <= val_nxt;
    dist_r  <= dist_nxt;
    lh_r    <= lh_nxt;
    out_r   <= out_nxt;
  end

  assign mem_we = clearing_r || (take && (q_item.mode == MODE_MAP_WRITE));
  assign mem_wa = clearing_r ? clr_addr_r : {q_item.cell_x, q_item.cell_y};
  assign mem_wd = clearing_r ? 8'd0 : q_item.cell_value;
  assign mem_ra = {mx_nxt[5:0], my_nxt[5:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= map_mem[mem_ra];
  end

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// Grid ray caster column testbench
// Drives map writes and column casts through the input queue, predicts each
// cast result with a fixed-point DDA walk over a local copy of the map and
// camera, and checks every popped result field by field, across several
// camera settings and idle patterns on both sides.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import grc_pkg::*;

  localparam int SW = SCREEN_WIDTH_DEF;
  localparam int SH = SCREEN_HEIGHT_DEF;
  localparam int GS = GRID_SIZE_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = REG_CAM_POS_X;
  logic [15:0] cfg_data = '0;

  grid_ray_caster_column u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [7:0] grid_map [MAP_DEPTH];
  logic [15:0] cam_reg [6];
  in_item_t item_q[$];
  out_item_t hit_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_send = 0;

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  function automatic longint step_len(longint r);
    longint m;
    m = r < 0 ? -r : r;
    return m == 0 ? (longint'(1) << 40) : (longint'(1) << 30) / m;
  endfunction

  task automatic cast_column(in_item_t it);
    longint c, cam, rx, ry, dx, dy, mx, my, fx, fy, sx, sy, sdx, sdy;
    longint num, d, wall_dist, lh, rs, re, px, py;
    int side, left;
    bit done;
    logic [7:0] val;
    out_item_t r;
    if (it.mode == MODE_MAP_WRITE) begin
      grid_map[{it.cell_x, it.cell_y}] = it.cell_value;
      return;
    end
    side = 0; left = 0; done = 0; val = 0;
    c = it.column;
    if (c >= SW) c = SW - 1;
    cam = (2 * c * 16384) / SW - 16384;
    rx = longint'($signed(cam_reg[REG_VIEW_DIR_X]))
       + ((longint'($signed(cam_reg[REG_CAM_PLANE_X])) * cam) >>> 14);
    ry = longint'($signed(cam_reg[REG_VIEW_DIR_Y]))
       + ((longint'($signed(cam_reg[REG_CAM_PLANE_Y])) * cam) >>> 14);
    dx = step_len(rx);
    dy = step_len(ry);
    px = cam_reg[REG_CAM_POS_X];
    py = cam_reg[REG_CAM_POS_Y];
    mx = px >> 10; my = py >> 10;
    fx = px & 1023; fy = py & 1023;
    sx = rx < 0 ? -1 : 1;
    sy = ry < 0 ? -1 : 1;
    sdx = ((rx < 0 ? fx : 1024 - fx) * dx) >> 10;
    sdy = ((ry < 0 ? fy : 1024 - fy) * dy) >> 10;
    if (mx >= GS || my >= GS) begin
      left = 1; done = 1;
    end
    for (int n = 0; n < 2 * GS + 4 && !done; n++) begin
      if (sdx < sdy) begin
        sdx += dx; mx += sx; side = 0;
      end else begin
        sdy += dy; my += sy; side = 1;
      end
      if (mx < 0 || my < 0 || mx >= GS || my >= GS) begin
        left = 1; done = 1;
      end else begin
        val = grid_map[mx * 64 + my];
        if (val != 0) done = 1;
      end
    end
    if (!done) left = 1;
    if (left) begin
      wall_dist = 65535; lh = 0; mx = 0; my = 0; val = 0;
    end else begin
      if (side == 0) begin
        num = mx * 1024 - px + (sx < 0 ? 1024 : 0);
        d = rx < 0 ? -rx : rx;
      end else begin
        num = my * 1024 - py + (sy < 0 ? 1024 : 0);
        d = ry < 0 ? -ry : ry;
      end
      if (num < 0) num = -num;
      if (d == 0) wall_dist = 65535;
      else begin
        wall_dist = (num << 12) / d;
        if (wall_dist > 65535) wall_dist = 65535;
      end
      if (wall_dist == 0) lh = 65535;
      else begin
        lh = (SH * 256) / wall_dist;
        if (lh > 65535) lh = 65535;
      end
    end
    rs = SH / 2 - lh / 2;
    if (rs < 0) rs = 0;
    re = lh / 2 + SH / 2;
    if (re >= SH) re = SH - 1;
    r.column_out = it.column;
    r.wall_side = side[0];
    r.hit_x = mx[5:0];
    r.hit_y = my[5:0];
    r.hit_value = val;
    r.wall_distance = wall_dist[15:0];
    r.line_height = lh[15:0];
    r.row_start = rs[9:0];
    r.row_end = re[9:0];
    r.left_grid = left[0];
    hit_q.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        cast_column(in_data);
        void'(item_q.pop_front());
      end
      if (hold_send || item_q.size() == 0 || $urandom_range(99) < send_idle) begin
        in_push <= 1'b0;
      end else begin
        in_push <= 1'b1;
        in_data <= item_q[0];
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (hit_q.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          out_item_t e;
          e = hit_q.pop_front();
          if (out_data.column_out !== e.column_out)
            report("column_out", out_data.column_out, e.column_out);
          if (out_data.wall_side !== e.wall_side)
            report("wall_side", out_data.wall_side, e.wall_side);
          if (out_data.hit_x !== e.hit_x) report("hit_x", out_data.hit_x, e.hit_x);
          if (out_data.hit_y !== e.hit_y) report("hit_y", out_data.hit_y, e.hit_y);
          if (out_data.hit_value !== e.hit_value)
            report("hit_value", out_data.hit_value, e.hit_value);
          if (out_data.wall_distance !== e.wall_distance)
            report("wall_distance", out_data.wall_distance, e.wall_distance);
          if (out_data.line_height !== e.line_height)
            report("line_height", out_data.line_height, e.line_height);
          if (out_data.row_start !== e.row_start)
            report("row_start", out_data.row_start, e.row_start);
          if (out_data.row_end !== e.row_end)
            report("row_end", out_data.row_end, e.row_end);
          if (out_data.left_grid !== e.left_grid)
            report("left_grid", out_data.left_grid, e.left_grid);
        end
      end
      out_pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic in_item_t map_item(int x, int y, int v);
    in_item_t it;
    it = '0;
    it.mode = MODE_MAP_WRITE;
    it.column = 10'($urandom_range(1023));
    it.cell_x = 6'(x); it.cell_y = 6'(y); it.cell_value = 8'(v);
    return it;
  endfunction

  function automatic in_item_t cast_item(int col);
    in_item_t it;
    it = '0;
    it.mode = MODE_CAST;
    it.column = 10'(col);
    it.cell_x = 6'($urandom_range(63)); it.cell_y = 6'($urandom_range(63));
    it.cell_value = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic set_camera(logic [15:0] v0, v1, v2, v3, v4, v5);
    logic [15:0] vals [6];
    vals = '{v0, v1, v2, v3, v4, v5};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      cam_reg[i] = vals[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    while (item_q.size() != 0 || in_push || hit_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < MAP_DEPTH; i++) grid_map[i] = 8'd0;
    cam_reg = '{RST_CAM_POS_X, RST_CAM_POS_Y, RST_VIEW_DIR_X, RST_VIEW_DIR_Y,
                RST_CAM_PLANE_X, RST_CAM_PLANE_Y};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_camera(16'd5120, 16'd33280, -16'sd16384, 16'd0, 16'd0, 16'd10813);
        1: set_camera(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        2: set_camera(16'd30000, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd0);
        3: set_camera(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        default: set_camera(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                            16'($urandom_range(65535)), 16'($urandom_range(65535)),
                            16'($urandom_range(65535)), 16'($urandom_range(65535)));
      endcase
      send_idle = ph < 2 ? 18 : (ph < 4 ? 55 : 0);
      recv_idle = ph < 2 ? 55 : (ph < 4 ? 18 : 0);
      if (ph == 0) begin
        // wall right at the camera's x boundary: zero distance, zero y component
        item_q.push_back(map_item(4, 32, 7));
        item_q.push_back(cast_item(320));
        item_q.push_back(map_item(63, 63, 255));
        item_q.push_back(map_item(0, 0, 1));
        item_q.push_back(map_item(0, 40, 128));
        item_q.push_back(cast_item(0));
        item_q.push_back(cast_item(639));
        item_q.push_back(cast_item(640));
        item_q.push_back(cast_item(1023));
        item_q.push_back(map_item(4, 32, 0));
        item_q.push_back(cast_item(320));
        item_q.push_back(cast_item(100));
        item_q.push_back(map_item(63, 0, 85));
        item_q.push_back(map_item(42, 21, 170));
        item_q.push_back(cast_item(513));
      end
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(99) < 60) begin
          item_q.push_back(cast_item($urandom_range(99) < 70 ?
                                     $urandom_range(SW - 1) : $urandom_range(1023)));
        end else begin
          item_q.push_back(map_item($urandom_range(63), $urandom_range(63),
                                    $urandom_range(99) < 75 ? $urandom_range(1, 255) : 0));
        end
        if (ph == 1 && i == 60) begin
          while (item_q.size() != 0 || in_push) @(posedge clk);
          hold_send = 1;
          while (hit_q.size() != 0) @(posedge clk);
          hold_send = 0;
        end
      end
      wait_idle();
    end

    if (hit_q.size() != 0) report("items left over", hit_q.size(), 0);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/grc_pkg.sv
hw/rtl/grc_front.sv
hw/rtl/grc_div.sv
hw/rtl/grc_core.sv
hw/rtl/grid_ray_caster_column.sv
dv/tb_top.sv
